// ===== rtl/core/flash_job_sequencer_defines.svh =====
// Assertion macros for the checker file of the flash job sequencer.
`ifndef FLASH_JOB_SEQUENCER_DEFINES_SVH
`define FLASH_JOB_SEQUENCER_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define FJS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds through reset
`define FJS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/fjs_pkg.sv =====
`timescale 1ns / 1ps

package fjs_pkg;

    // Request and tick codes
    localparam logic [1:0] ACT_ERASE = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Result kinds
    localparam logic [2:0] K_ACCEPT       = 3'd0;
    localparam logic [2:0] K_REFUSE       = 3'd1;
    localparam logic [2:0] K_ERASE_START  = 3'd2;
    localparam logic [2:0] K_ERASE_FINISH = 3'd3;
    localparam logic [2:0] K_WRITE_ENABLE = 3'd4;
    localparam logic [2:0] K_BYTE_WRITE   = 3'd5;
    localparam logic [2:0] K_BYTE_READ    = 3'd6;
    localparam logic [2:0] K_NOTHING      = 3'd7;

    // Job kinds
    localparam logic [1:0] JOB_NONE  = 2'd0;
    localparam logic [1:0] JOB_ERASE = 2'd1;
    localparam logic [1:0] JOB_WRITE = 2'd2;
    localparam logic [1:0] JOB_READ  = 2'd3;

    // Job phases
    localparam logic [1:0] PH_IDLE       = 2'd0;
    localparam logic [1:0] PH_PENDING    = 2'd1;
    localparam logic [1:0] PH_PROCESSING = 2'd2;

    // Segment numbering and start addresses
    localparam logic [1:0]  SEG_INVALID = 2'd3;
    localparam logic [15:0] SEG0_BASE   = 16'h1080;
    localparam logic [15:0] SEG1_BASE   = 16'h1040;
    localparam logic [15:0] SEG2_BASE   = 16'h1000;

    // One input transaction, unpacked
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  segment;
        logic [15:0] buffer_address;
        logic [7:0]  length;
        logic        flash_busy;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] flash_address;
        logic [15:0] buffer_address_out;
        logic [1:0]  job_status;
        logic        last;
        logic        job_done;
    } t_result;

    // Start address of a valid segment
    function automatic logic [15:0] seg_base(input logic [1:0] seg);
        logic [15:0] base;
        case (seg)
            2'd0:    base = SEG0_BASE;
            2'd1:    base = SEG1_BASE;
            default: base = SEG2_BASE;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/core/flash_job_sequencer.sv =====
`timescale 1ns / 1ps

// Flash job sequencer: takes erase, write and read requests for one of three
// flash segments and tick transactions that move the single active job
// forward, and reports every flash operation as a result transaction. A
// request or a tick that yields one result passes the engine through capture,
// then decide; a write or read tick yields n byte results, with n at most
// WRITE_CHUNK or READ_CHUNK, and after the decide step one shared pointer
// step advances the flash and buffer addresses one byte a cycle while the
// output does not stall. The input is ready only while the engine is free; a
// registered output stage lets the next input in while the last result still
// waits, and a stalled output holds the engine in place.
module flash_job_sequencer #(
    parameter int SEGMENT_BYTES = 64,
    parameter int WRITE_CHUNK   = 8,
    parameter int READ_CHUNK    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] segment, [17:2] buffer_address, [25:18] length, [26] flash_busy
    input  logic [31:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] flash_address, [31:16] buffer_address_out, [33:32] job_status,
    // [34] job_done
    output logic [39:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import fjs_pkg::*;

    t_item   item;
    t_result eng_res;
    t_result r_out;
    logic    r_out_valid;
    logic    eng_idle;
    logic    eng_res_valid;
    logic    adv;
    logic    start;

    // Unpack the input transaction
    assign item.action         = s_axis_tuser;
    assign item.segment        = s_axis_tdata[1:0];
    assign item.buffer_address = s_axis_tdata[17:2];
    assign item.length         = s_axis_tdata[25:18];
    assign item.flash_busy     = s_axis_tdata[26];

    assign s_axis_tready = eng_idle;
    assign start         = s_axis_tvalid && eng_idle;
    assign adv           = !r_out_valid || m_axis_tready;

    fjs_engine #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .WRITE_CHUNK   (WRITE_CHUNK),
        .READ_CHUNK    (READ_CHUNK)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_adv       (adv),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .o_res       (eng_res)
    );

    // Output register: load on a free slot, drop on a completed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_valid && adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid && adv) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.job_done, r_out.job_status,
                            r_out.buffer_address_out, r_out.flash_address};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

// ===== rtl/core/fjs_engine.sv =====
`timescale 1ns / 1ps

module fjs_engine #(
    parameter int SEGMENT_BYTES = 64,
    parameter int WRITE_CHUNK   = 8,
    parameter int READ_CHUNK    = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fjs_pkg::t_item  i_item,
    input  logic            i_adv,
    output logic            o_idle,
    output logic            o_res_valid,
    output fjs_pkg::t_result o_res
);
    import fjs_pkg::*;

    localparam int CHUNK_MAX = (WRITE_CHUNK > READ_CHUNK) ? WRITE_CHUNK : READ_CHUNK;
    localparam int CNT_W     = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_BYTES  = 2'd2;

    logic [1:0]       r_st, n_st;
    logic [1:0]       r_job_kind, n_job_kind;
    logic [1:0]       r_job_phase, n_job_phase;
    logic [7:0]       r_left, n_left;
    logic [15:0]      r_fptr, n_fptr;
    logic [15:0]      r_bptr, n_bptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_status, n_status;
    logic             r_wr, n_wr;
    t_item            r_item;

    logic             res_valid;
    t_result          res;

    // Latch the transaction while the engine is free
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_job_kind  <= JOB_NONE;
            r_job_phase <= PH_IDLE;
            r_left      <= '0;
            r_fptr      <= '0;
            r_bptr      <= '0;
            r_cnt       <= '0;
            r_status    <= PH_IDLE;
            r_wr        <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_job_kind  <= n_job_kind;
            r_job_phase <= n_job_phase;
            r_left      <= n_left;
            r_fptr      <= n_fptr;
            r_bptr      <= n_bptr;
            r_cnt       <= n_cnt;
            r_status    <= n_status;
            r_wr        <= n_wr;
        end
    end

    // Decide one step, then walk the byte chunk one byte per cycle while the output is not stalled
    always_comb begin
        logic             bad;
        logic             fin;
        logic             end_chunk;
        logic [CNT_W-1:0] cnt_top;
        logic [7:0]       chunk_len;

        n_st        = r_st;
        n_job_kind  = r_job_kind;
        n_job_phase = r_job_phase;
        n_left      = r_left;
        n_fptr      = r_fptr;
        n_bptr      = r_bptr;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_wr        = r_wr;
        res_valid   = 1'b0;
        res         = '0;
        bad         = 1'b0;
        fin         = (r_left == 8'd1);
        cnt_top     = r_wr ? CNT_W'(WRITE_CHUNK - 1) : CNT_W'(READ_CHUNK - 1);
        end_chunk   = (r_cnt == cnt_top);
        chunk_len   = (r_job_kind == JOB_WRITE) ? 8'(WRITE_CHUNK) : 8'(READ_CHUNK);

        case (r_st)
            ST_IDLE: begin
                if (i_start) begin
                    n_st = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res.last = 1'b1;
                if (r_item.action != ACT_TICK) begin
                    // Request: refuse or open a job
                    bad = (r_job_phase != PH_IDLE) || (r_item.segment == SEG_INVALID);
                    if (r_item.action != ACT_ERASE) begin
                        if ((r_item.buffer_address == '0) || (r_item.length == '0)) begin
                            bad = 1'b1;
                        end
                        if ((r_item.action == ACT_WRITE) &&
                            (r_item.length > 8'(SEGMENT_BYTES))) begin
                            bad = 1'b1;
                        end
                    end
                    res_valid = 1'b1;
                    if (bad) begin
                        res.kind       = K_REFUSE;
                        res.job_status = r_job_phase;
                    end else begin
                        res.kind          = K_ACCEPT;
                        res.flash_address = seg_base(r_item.segment);
                        if (r_item.action == ACT_ERASE) begin
                            res.job_status = PH_PENDING;
                        end else begin
                            res.buffer_address_out = r_item.buffer_address;
                            res.job_status = (r_item.action == ACT_WRITE) ?
                                             PH_PENDING : PH_PROCESSING;
                        end
                        if (i_adv) begin
                            n_fptr      = seg_base(r_item.segment);
                            n_job_phase = res.job_status;
                            if (r_item.action == ACT_ERASE) begin
                                n_job_kind = JOB_ERASE;
                                n_left     = '0;
                                n_bptr     = '0;
                            end else begin
                                n_job_kind = (r_item.action == ACT_WRITE) ?
                                             JOB_WRITE : JOB_READ;
                                n_left     = r_item.length;
                                n_bptr     = r_item.buffer_address;
                            end
                        end
                    end
                    if (i_adv) begin
                        n_st = ST_IDLE;
                    end
                end else if ((r_job_kind == JOB_ERASE) && (r_job_phase == PH_PENDING) &&
                             !r_item.flash_busy) begin
                    res_valid         = 1'b1;
                    res.kind          = K_ERASE_START;
                    res.flash_address = r_fptr;
                    res.job_status    = PH_PROCESSING;
                    if (i_adv) begin
                        n_job_phase = PH_PROCESSING;
                        n_st        = ST_IDLE;
                    end
                end else if ((r_job_kind == JOB_ERASE) && (r_job_phase == PH_PROCESSING) &&
                             !r_item.flash_busy) begin
                    res_valid         = 1'b1;
                    res.kind          = K_ERASE_FINISH;
                    res.flash_address = r_fptr;
                    res.job_status    = PH_IDLE;
                    res.job_done      = 1'b1;
                    if (i_adv) begin
                        n_job_kind  = JOB_NONE;
                        n_job_phase = PH_IDLE;
                        n_left      = '0;
                        n_fptr      = '0;
                        n_bptr      = '0;
                        n_st        = ST_IDLE;
                    end
                end else if ((r_job_kind == JOB_WRITE) && (r_job_phase == PH_PENDING) &&
                             !r_item.flash_busy) begin
                    res_valid              = 1'b1;
                    res.kind               = K_WRITE_ENABLE;
                    res.flash_address      = r_fptr;
                    res.buffer_address_out = r_bptr;
                    res.job_status         = PH_PROCESSING;
                    if (i_adv) begin
                        n_job_phase = PH_PROCESSING;
                        n_st        = ST_IDLE;
                    end
                end else if (((r_job_kind == JOB_WRITE) && (r_job_phase == PH_PROCESSING) &&
                              !r_item.flash_busy) ||
                             ((r_job_kind == JOB_READ) && (r_job_phase == PH_PROCESSING))) begin
                    // Set up the byte walk; the final status is known up front
                    n_wr     = (r_job_kind == JOB_WRITE);
                    n_cnt    = '0;
                    n_status = (r_left <= chunk_len) ? PH_IDLE : PH_PROCESSING;
                    n_st     = ST_BYTES;
                end else begin
                    res_valid      = 1'b1;
                    res.kind       = K_NOTHING;
                    res.job_status = r_job_phase;
                    if (i_adv) begin
                        n_st = ST_IDLE;
                    end
                end
            end
            ST_BYTES: begin
                res_valid              = 1'b1;
                res.kind               = r_wr ? K_BYTE_WRITE : K_BYTE_READ;
                res.flash_address      = r_fptr;
                res.buffer_address_out = r_bptr;
                res.job_status         = r_status;
                res.job_done           = fin;
                res.last               = fin || end_chunk;
                if (i_adv) begin
                    // Advance both pointers through the shared byte step
                    n_left = r_left - 8'd1;
                    n_fptr = r_fptr + 16'd1;
                    n_bptr = r_bptr + 16'd1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (fin) begin
                        n_job_kind  = JOB_NONE;
                        n_job_phase = PH_IDLE;
                        n_left      = '0;
                        n_fptr      = '0;
                        n_bptr      = '0;
                    end
                    if (fin || end_chunk) begin
                        n_st = ST_IDLE;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_st == ST_IDLE);
    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

// ===== rtl/core/fjs_checker.sv =====
`timescale 1ns / 1ps
`include "flash_job_sequencer_defines.svh"

module fjs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import fjs_pkg::*;

    // Reset empties the output and frees the input side
    `FJS_ASSERT_RST(a_reset_clean, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "output not empty after reset")

    // A stalled result holds
    `FJS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // A taken transaction keeps the engine busy for the next cycle
    `FJS_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after a take")

    // A free engine leaves only the final result of a step waiting
    `FJS_ASSERT(a_idle_last, s_axis_tready && m_axis_tvalid |-> m_axis_tlast, "non-final result pending while free")

    // Accept, refuse and nothing results and job completion always close the step
    `FJS_ASSERT(a_single_last, m_axis_tvalid && (m_axis_tuser == K_ACCEPT || m_axis_tuser == K_REFUSE || m_axis_tuser == K_NOTHING || m_axis_tdata[34]) |-> m_axis_tlast, "single result or job end without tlast")

endmodule

bind flash_job_sequencer fjs_checker u_fjs_checker (.*);
